### rtl/core/slc_pkg.sv
// Shared types, constants and the square-root step for the seam link classifier.
// Depends on nothing; every other file of the block imports it.
package slc_pkg;

    // Field widths of one item.
    localparam int LABEL_W  = 16;
    localparam int PIX_W    = 48;
    localparam int THRESH_W = 15;
    localparam int COST_W   = 15;

    // Datapath widths inside a lane.
    localparam int MAG_W    = 9;   // largest difference is 340
    localparam int SQ_W     = 17;  // 340 squared fits in 17 bits
    localparam int SUM_W    = 19;  // three squares
    localparam int RAD_W    = 28;  // sum times 256, padded to an even width
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 1;

    // Reciprocal of three for values below 2048: floor(x / 3) = (x * 683) >> 11.
    localparam int RECIP3     = 683;
    localparam int RECIP3_SH  = 11;

    // Pipeline depth: difference, square, sum, then two root digits per stage.
    localparam int SQRT_STAGES = ROOT_W / 2;
    localparam int LANE_LAT    = 3 + SQRT_STAGES;

    localparam int NUM_COLORS = 3;

    typedef enum logic [1:0] {
        LINK_NORMAL = 2'd0,
        LINK_BLEND  = 2'd1,
        LINK_IGNORE = 2'd2
    } link_type_t;

    // Per-item control that travels beside the lanes.
    typedef struct packed {
        logic beyond_image;
        logic same_label;
    } slc_ctl_t;

    // Partial remainder and root of the digit-by-digit square root.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_acc_t;

    // One restoring square-root step: brings in two radicand bits, yields one root bit.
    function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
        sqrt_acc_t        res;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] test;
        trial = {acc.rem, pair};
        test  = {{(REM_W - ROOT_W){1'b0}}, acc.root, 2'b01};
        if (trial >= test) begin
            res.rem  = REM_W'(trial - test);
            res.root = {acc.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = trial[REM_W-1:0];
            res.root = {acc.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

### rtl/core/seam_link_classifier_unit.sv
// Top level of the seam link classifier: stream ports, pipeline control, two lanes.
// Depends on slc_pkg, slc_lane and slc_merge.
//
// Each item is one pixel link; it yields exactly one result item, and a new item can
// be accepted every cycle unless a stalled output has filled all stages. The depth is
// set by the difference, square and sum stages followed by a seven-stage square root
// that resolves two root digits per stage, plus the merging register. Both source
// images are handled side by side in two lanes, the three colors inside a lane in
// parallel. Every stage holds when the one after it is full and stalled, so a
// stalled output only stops the input once all stages are occupied. The threshold
// register may be written only while no item is in flight.
module seam_link_classifier_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: edge_threshold in Q11.4.
    input  logic                          cfg_wr_en,
    input  logic [slc_pkg::THRESH_W-1:0]  cfg_wr_data,
    // Input channel.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata from bit 0: label_first[15:0], label_second[31:16], first_img_red[79:32],
    // first_img_green[127:80], first_img_blue[175:128], second_img_red[223:176],
    // second_img_green[271:224], second_img_blue[319:272].
    input  logic [319:0]                  s_axis_tdata,
    // tuser from bit 0: beyond_image[0], short_cross[1].
    input  logic [1:0]                    s_axis_tuser,
    // Result channel.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata from bit 0: seam_cost[14:0], zero fill [15].
    output logic [15:0]                   m_axis_tdata,
    // tuser from bit 0: link_type[1:0].
    output logic [1:0]                    m_axis_tuser
);
    import slc_pkg::*;

    logic [THRESH_W-1:0]       thresh_reg;
    logic [LANE_LAT-1:0]       vld_reg;
    slc_ctl_t                  ctl_reg [LANE_LAT];
    logic                      out_valid_reg;
    logic                      out_en;
    logic [LANE_LAT-1:0]       stage_en;
    slc_ctl_t                  ctl_in;
    logic [ROOT_W-1:0]         root_first;
    logic [ROOT_W-1:0]         root_second;
    link_type_t                link_type;
    logic [COST_W-1:0]         seam_cost;
    logic [NUM_COLORS-1:0][PIX_W-1:0] pix_first;
    logic [NUM_COLORS-1:0][PIX_W-1:0] pix_second;

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= '0;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    // A stage loads when it is empty or its successor loads.
    assign out_en = !out_valid_reg || m_axis_tready;
    always_comb begin
        stage_en[LANE_LAT-1] = !vld_reg[LANE_LAT-1] || out_en;
        for (int k = LANE_LAT - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end
    assign s_axis_tready = stage_en[0];

    // Valid bits of the stages and of the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (stage_en[0]) begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < LANE_LAT; k++) begin
                if (stage_en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (out_en) begin
                out_valid_reg <= vld_reg[LANE_LAT-1];
            end
        end
    end

    // Control bits of each item travel beside the lanes.
    assign ctl_in.beyond_image = s_axis_tuser[0];
    assign ctl_in.same_label   = (s_axis_tdata[15:0] == s_axis_tdata[31:16]);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            ctl_reg[0] <= ctl_in;
        end
        for (int k = 1; k < LANE_LAT; k++) begin
            if (stage_en[k]) begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // Color words of each source image, red first.
    assign pix_first  = {s_axis_tdata[175:128], s_axis_tdata[127:80], s_axis_tdata[79:32]};
    assign pix_second = {s_axis_tdata[319:272], s_axis_tdata[271:224], s_axis_tdata[223:176]};

    slc_lane u_lane_first (
        .aclk        (aclk),
        .stage_en    (stage_en),
        .short_cross (s_axis_tuser[1]),
        .pix         (pix_first),
        .root        (root_first)
    );

    slc_lane u_lane_second (
        .aclk        (aclk),
        .stage_en    (stage_en),
        .short_cross (s_axis_tuser[1]),
        .pix         (pix_second),
        .root        (root_second)
    );

    slc_merge u_merge (
        .aclk        (aclk),
        .load        (out_en),
        .ctl         (ctl_reg[LANE_LAT-1]),
        .root_first  (root_first),
        .root_second (root_second),
        .threshold   (thresh_reg),
        .link_type   (link_type),
        .seam_cost   (seam_cost)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, seam_cost};
    assign m_axis_tuser  = link_type;

    // A normal link never carries a cost.
    a_normal_zero_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (link_type == LINK_NORMAL)) |-> (seam_cost == '0))
        else $error("normal link with nonzero seam cost");

    // A blend link always has a cost below the threshold.
    a_blend_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (link_type == LINK_BLEND)) |-> (seam_cost < thresh_reg))
        else $error("blend link with cost not below threshold");

    // Input backpressure only arises from a stalled result register with all stages full.
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&vld_reg)))
        else $error("input stalled without a full, stalled pipeline");

endmodule

### rtl/core/slc_lane.sv
// One lane: seam cost root of one source image over its three colors.
// Depends on slc_pkg; stage enables come from the top-level pipeline control.
module slc_lane (
    input  logic                                      aclk,
    input  logic [slc_pkg::LANE_LAT-1:0]              stage_en,
    input  logic                                      short_cross,
    input  logic [slc_pkg::NUM_COLORS-1:0][slc_pkg::PIX_W-1:0] pix,
    output logic [slc_pkg::ROOT_W-1:0]                root
);
    import slc_pkg::*;

    logic [NUM_COLORS-1:0][MAG_W-1:0] mag_next;
    logic [NUM_COLORS-1:0][MAG_W-1:0] mag_reg;
    logic [NUM_COLORS-1:0][SQ_W-1:0]  sq_reg;
    logic [SUM_W-1:0]                 sum_reg;
    logic [RAD_W-1:0]                 rad_first;
    sqrt_acc_t                        acc_reg [SQRT_STAGES];
    logic [RAD_W-1:0]                 rad_reg [SQRT_STAGES];

    // Cross-seam difference magnitude per color, smoothed or plain.
    always_comb begin
        for (int c = 0; c < NUM_COLORS; c++) begin
            logic [9:0]  sum_a;
            logic [9:0]  sum_b;
            logic [9:0]  diff;
            logic [19:0] prod;
            logic [7:0]  plain;
            sum_a = {2'b00, pix[c][47:40]} + {1'b0, pix[c][39:32], 1'b0}
                  + {2'b00, pix[c][31:24]};
            sum_b = {2'b00, pix[c][23:16]} + {1'b0, pix[c][15:8], 1'b0}
                  + {2'b00, pix[c][7:0]};
            diff  = (sum_a >= sum_b) ? (sum_a - sum_b) : (sum_b - sum_a);
            prod  = {10'd0, diff} * 20'(RECIP3);
            plain = (pix[c][39:32] >= pix[c][15:8]) ? (pix[c][39:32] - pix[c][15:8])
                                                    : (pix[c][15:8] - pix[c][39:32]);
            mag_next[c] = short_cross ? {1'b0, plain}
                                      : prod[RECIP3_SH +: MAG_W];
        end
    end

    // Difference, square and sum stages.
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            mag_reg <= mag_next;
        end
        if (stage_en[1]) begin
            for (int c = 0; c < NUM_COLORS; c++) begin
                sq_reg[c] <= SQ_W'({{(SQ_W - MAG_W){1'b0}}, mag_reg[c]}
                                   * {{(SQ_W - MAG_W){1'b0}}, mag_reg[c]});
            end
        end
        if (stage_en[2]) begin
            sum_reg <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        end
    end

    // The root of sum * 256 comes out in Q.4.
    assign rad_first = {{(RAD_W - SUM_W - 8){1'b0}}, sum_reg, 8'd0};

    // Square root, two digits per stage, high radicand bits first.
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        localparam int P_HI = 2 * SQRT_STAGES - 1 - 2 * k;
        localparam int P_LO = P_HI - 1;
        sqrt_acc_t        acc_in;
        logic [RAD_W-1:0] rad_in;
        sqrt_acc_t        acc_mid;

        if (k == 0) begin : g_head
            assign acc_in = '0;
            assign rad_in = rad_first;
        end else begin : g_body
            assign acc_in = acc_reg[k-1];
            assign rad_in = rad_reg[k-1];
        end

        assign acc_mid = sqrt_step(acc_in, rad_in[2*P_HI +: 2]);

        always_ff @(posedge aclk) begin
            if (stage_en[3+k]) begin
                acc_reg[k] <= sqrt_step(acc_mid, rad_in[2*P_LO +: 2]);
                rad_reg[k] <= rad_in;
            end
        end
    end

    assign root = acc_reg[SQRT_STAGES-1].root;

endmodule

### rtl/core/slc_merge.sv
// Merging stage: adds the two lane roots and decides the link type.
// Depends on slc_pkg; holds the result register that feeds the output port.
module slc_merge (
    input  logic                          aclk,
    input  logic                          load,
    input  slc_pkg::slc_ctl_t             ctl,
    input  logic [slc_pkg::ROOT_W-1:0]    root_first,
    input  logic [slc_pkg::ROOT_W-1:0]    root_second,
    input  logic [slc_pkg::THRESH_W-1:0]  threshold,
    output slc_pkg::link_type_t           link_type,
    output logic [slc_pkg::COST_W-1:0]    seam_cost
);
    import slc_pkg::*;

    logic [COST_W-1:0] cost;
    link_type_t        type_next;
    logic [COST_W-1:0] cost_next;
    link_type_t        type_reg;
    logic [COST_W-1:0] cost_reg;

    assign cost = COST_W'({1'b0, root_first} + {1'b0, root_second});

    // Out of image wins over matching labels; otherwise the cost decides.
    always_comb begin
        if (ctl.beyond_image) begin
            type_next = LINK_IGNORE;
            cost_next = '0;
        end else if (ctl.same_label) begin
            type_next = LINK_NORMAL;
            cost_next = '0;
        end else begin
            type_next = (cost < threshold) ? LINK_BLEND : LINK_IGNORE;
            cost_next = cost;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            type_reg <= type_next;
            cost_reg <= cost_next;
        end
    end

    assign link_type = type_reg;
    assign seam_cost = cost_reg;

endmodule

### tb/seam_link_checker.sv
// Result checker for the seam link classifier: predicts each link from the input stream.
// It compares every result item in order and reports the error and in-flight counts to the top.
// Depends on slc_pkg for the link codes and field widths.
`timescale 1ns / 100ps

module seam_link_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [slc_pkg::THRESH_W-1:0]  cfg_wr_data,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [319:0]                  s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [15:0]                   m_axis_tdata,
    input  logic [1:0]                    m_axis_tuser,
    output int                            mismatch_count,
    output int                            outstanding_count
);
    import slc_pkg::*;

    typedef struct packed {
        link_type_t        kind;
        logic [COST_W-1:0] cost;
    } link_verdict_t;

    // Predicted results, oldest first.
    link_verdict_t       awaited_links[$];
    logic [THRESH_W-1:0] threshold_copy;
    int                  errors;

    // Magnitude of the cross-seam difference in one color row of six bytes.
    function automatic int unsigned cross_gap(logic [PIX_W-1:0] row, logic plain);
        logic [7:0] a_prev, a_mid, a_next, b_prev, b_mid, b_next;
        int         side_a, side_b, gap;
        {a_prev, a_mid, a_next, b_prev, b_mid, b_next} = row;
        if (plain) begin
            side_a = int'(a_mid);
            side_b = int'(b_mid);
        end else begin
            side_a = a_prev + 2 * a_mid + a_next;
            side_b = b_prev + 2 * b_mid + b_next;
        end
        gap = (side_a >= side_b) ? side_a - side_b : side_b - side_a;
        return plain ? gap : gap / 3;
    endfunction

    // Largest integer whose square does not exceed the argument.
    function automatic int unsigned floor_root(int unsigned radicand);
        int unsigned root, trial;
        root = 0;
        for (int bit_pos = ROOT_W - 1; bit_pos >= 0; bit_pos--) begin
            trial = root | (32'd1 << bit_pos);
            if (trial * trial <= radicand) root = trial;
        end
        return root;
    endfunction

    // Root of the summed squared color differences of one source image, in Q.4.
    function automatic int unsigned image_seam_root(logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                                                    logic [PIX_W-1:0] blue, logic plain);
        int unsigned gr, gg, gb, total;
        gr    = cross_gap(red, plain);
        gg    = cross_gap(green, plain);
        gb    = cross_gap(blue, plain);
        total = gr * gr + gg * gg + gb * gb;
        return floor_root(total << 8);
    endfunction

    // Expected result item for one link.
    function automatic link_verdict_t classify_link(logic [1:0] flags, logic [319:0] fields,
                                                    logic [THRESH_W-1:0] limit);
        link_verdict_t verdict;
        int unsigned   seam_sum;
        verdict.kind = LINK_IGNORE;
        verdict.cost = '0;
        if (flags[0]) return verdict;
        if (fields[15:0] == fields[31:16]) begin
            verdict.kind = LINK_NORMAL;
            return verdict;
        end
        seam_sum = image_seam_root(fields[79:32], fields[127:80], fields[175:128], flags[1])
                 + image_seam_root(fields[223:176], fields[271:224], fields[319:272], flags[1]);
        verdict.cost = seam_sum[COST_W-1:0];
        verdict.kind = (seam_sum < limit) ? LINK_BLEND : LINK_IGNORE;
        return verdict;
    endfunction

    // Watch both channels at every edge; the counters are published as registered copies.
    always @(posedge aclk) begin : watch
        link_verdict_t want;
        if (!aresetn) begin
            awaited_links.delete();
            threshold_copy = '0;
            errors         = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_links.insert(awaited_links.size(),
                                     classify_link(s_axis_tuser, s_axis_tdata, threshold_copy));
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_links.size() == 0) begin
                    errors++;
                    $display("%0t: result item with none expected, type %0d cost %0d",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = awaited_links.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        errors++;
                        $display("%0t: link type mismatch, expected %0d, actual %0d",
                                 $time, want.kind, m_axis_tuser);
                    end
                    if (m_axis_tdata !== {1'b0, want.cost}) begin
                        errors++;
                        $display("%0t: seam cost mismatch, expected %0d, actual %0d",
                                 $time, {1'b0, want.cost}, m_axis_tdata);
                    end
                end
            end
            if (cfg_wr_en) threshold_copy = cfg_wr_data;
        end
        mismatch_count    <= errors;
        outstanding_count <= awaited_links.size();
    end

endmodule

### tb/tb.sv
// Testbench top for the seam link classifier: clock, reset, stimulus and the final verdict.
// Depends on slc_pkg, seam_link_classifier_unit and seam_link_checker.
`timescale 1ns / 100ps

module tb;
    import slc_pkg::*;

    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_CYCLES     = 120;
    localparam int CYCLE_LIMIT     = 300000;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [THRESH_W-1:0] cfg_wr_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [319:0]        s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [15:0]         m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    int  mismatch_count;
    int  outstanding_count;
    int  cycle_count;
    bit  calm;
    bit  hold_request;
    bit  holding;

    seam_link_classifier_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    seam_link_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tuser      (s_axis_tuser),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser),
        .mismatch_count    (mismatch_count),
        .outstanding_count (outstanding_count)
    );

    // Free-running clock.
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Watchdog: a run that takes too long is a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: runs of ready cycles broken by short stalls, and one long hold-off on request.
    initial begin
        holding       = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                holding      = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holding = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    end

    // Offer one link item and wait until it is taken, sometimes idling first.
    task automatic send_link(input logic beyond, input logic short_x,
                             input logic [15:0] label_a, input logic [15:0] label_b,
                             input logic [PIX_W-1:0] fr, input logic [PIX_W-1:0] fg,
                             input logic [PIX_W-1:0] fb, input logic [PIX_W-1:0] sr,
                             input logic [PIX_W-1:0] sg, input logic [PIX_W-1:0] sb);
        if (!calm && !holding && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sb, sg, sr, fb, fg, fr, label_b, label_a};
        s_axis_tuser  <= {short_x, beyond};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Same six bytes in all three colors of each image.
    task automatic send_uniform(input logic beyond, input logic short_x,
                                input logic [15:0] label_a, input logic [15:0] label_b,
                                input logic [PIX_W-1:0] first_px, input logic [PIX_W-1:0] second_px);
        send_link(beyond, short_x, label_a, label_b,
                  first_px, first_px, first_px, second_px, second_px, second_px);
    endtask

    // Wait until every item has come back, then write the threshold.
    task automatic set_threshold(input logic [THRESH_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding_count != 0);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One color row: fully random, nearly flat (small costs) or flat (zero cost).
    function automatic logic [PIX_W-1:0] pixel_row(int unsigned style);
        logic [63:0]     wide;
        logic [PIX_W-1:0] row;
        logic [7:0]      base;
        wide = {$urandom, $urandom};
        base = 8'($urandom_range(0, 252));
        if (style < 10) begin
            row = wide[PIX_W-1:0];
        end else if (style < 17) begin
            for (int k = 0; k < 6; k++) row[8*k +: 8] = base + 8'($urandom_range(0, 3));
        end else begin
            row = {6{base}};
        end
        return row;
    endfunction

    // Random links: mostly real seams, some same-label and out-of-image ones.
    task automatic run_random_phase(input int count, input bit with_hold);
        int unsigned style;
        logic [15:0] label_a, label_b;
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == 8) hold_request = 1'b1;
            style   = $urandom_range(0, 19);
            label_a = 16'($urandom_range(0, 16'hFFFF));
            label_b = ($urandom_range(0, 3) == 0) ? label_a : 16'($urandom_range(0, 16'hFFFF));
            send_link($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)), label_a, label_b,
                      pixel_row(style), pixel_row(style), pixel_row(style),
                      pixel_row(style), pixel_row(style), pixel_row(style));
        end
    endtask

    // Main sequence.
    initial begin
        calm          = 1'b0;
        hold_request  = 1'b0;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed links. The threshold sits one above the plain-difference maximum of 14132.
        set_threshold(15'd14133);
        // Out of image wins over everything, labels equal or not.
        send_uniform(1'b1, 1'b0, 16'd1, 16'd2, 48'hFFFFFF_000000, 48'hFFFFFF_000000);
        send_uniform(1'b1, 1'b1, 16'd7, 16'd7, 48'hFFFFFF_FFFFFF, 48'h000000_000000);
        // Same labels give a normal link with no cost.
        send_uniform(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 48'hFFFFFF_000000, 48'h000000_FFFFFF);
        send_link(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                  48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        // A seam across flat images costs nothing and blends.
        send_uniform(1'b0, 1'b0, 16'h0000, 16'hFFFF, 48'h000000_000000, 48'h000000_000000);
        send_uniform(1'b0, 1'b1, 16'hFFFF, 16'hFFFE, 48'hFFFFFF_FFFFFF, 48'hFFFFFF_FFFFFF);
        // Steepest smoothed edge in both directions: cost 18844.
        send_uniform(1'b0, 1'b0, 16'd3, 16'd4, 48'hFFFFFF_000000, 48'hFFFFFF_000000);
        send_uniform(1'b0, 1'b0, 16'd4, 16'd3, 48'h000000_FFFFFF, 48'h000000_FFFFFF);
        // Steepest plain difference: 14132, just below the threshold.
        send_uniform(1'b0, 1'b1, 16'd5, 16'd6, 48'hFFFFFF_000000, 48'h000000_FFFFFF);
        // Alternating bytes: the smoothed difference cancels, the plain one does not.
        send_uniform(1'b0, 1'b0, 16'd8, 16'd9, 48'h00FF00_FF00FF, 48'h00FF00_FF00FF);
        send_uniform(1'b0, 1'b1, 16'd8, 16'd9, 48'h00FF00_FF00FF, 48'h00FF00_FF00FF);
        // Only the neighbors along the seam differ: plain zero, smoothed 170 per color.
        send_uniform(1'b0, 1'b1, 16'd10, 16'd11, 48'hFF00FF_000000, 48'hFF00FF_000000);
        send_uniform(1'b0, 1'b0, 16'd10, 16'd11, 48'hFF00FF_000000, 48'hFF00FF_000000);
        // Truncation of the divide by three, red only.
        send_link(1'b0, 1'b0, 16'd12, 16'd13, 48'h000001_000000, '0, '0, 48'h000000_000002, '0, '0);
        send_link(1'b0, 1'b0, 16'd12, 16'd13, 48'h000003_000000, '0, '0, 48'h000000_000004, '0, '0);
        // One steep image and one flat image.
        send_uniform(1'b0, 1'b0, 16'd14, 16'd15, 48'h000000_FFFFFF, 48'h808080_808080);
        // Cost equal to the threshold is not below it.
        set_threshold(15'd14132);
        send_uniform(1'b0, 1'b1, 16'd5, 16'd6, 48'hFFFFFF_000000, 48'h000000_FFFFFF);

        // Random phases over several thresholds, extremes included.
        set_threshold(15'd0);
        run_random_phase(ITEMS_PER_PHASE, 1'b0);
        set_threshold(15'd32767);
        run_random_phase(ITEMS_PER_PHASE, 1'b1);
        set_threshold(15'd1);
        run_random_phase(ITEMS_PER_PHASE, 1'b0);
        set_threshold(15'd600);
        run_random_phase(ITEMS_PER_PHASE, 1'b0);
        set_threshold(15'($urandom_range(2, 32766)));
        run_random_phase(ITEMS_PER_PHASE, 1'b0);
        // Last part runs at full rate on both sides.
        set_threshold(15'd5000);
        calm = 1'b1;
        run_random_phase(ITEMS_PER_PHASE, 1'b0);

        // Drain and give the verdict.
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding_count != 0);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && outstanding_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
